FILE: rtl/bezier_path_flattener_unit_macros.svh
// Assertion macros used by the path flattener sequencer.
`ifndef BEZIER_PATH_FLATTENER_UNIT_MACROS_SVH
`define BEZIER_PATH_FLATTENER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk_i, disabled during reset.
`define BPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, disabled during reset.
`define BPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bpf_pkg.sv
// Shared types and constants of the path flattener.
package bpf_pkg;

  localparam int unsigned MaxSegments = 64;
  localparam int unsigned CoordW      = 32;
  localparam int unsigned SegW        = 7;

  typedef enum logic [2:0] {
    ACT_RESTART   = 3'd0,
    ACT_LINE_REL  = 3'd1,
    ACT_QUAD_ABS  = 3'd2,
    ACT_QUAD_REL  = 3'd3,
    ACT_CUBIC_ABS = 3'd4,
    ACT_CUBIC_REL = 3'd5
  } action_e;

  typedef struct packed {
    logic       load;
    logic       wgt1;
    logic       wgt2;
    logic       mac;
    logic [1:0] term;
    logic       prep;
    logic       div_step;
    logic       emit;
  } bpf_cmd_t;

  typedef struct packed {
    logic is_curve;
    logic is_bad;
    logic at_last;
  } bpf_status_t;

endpackage

FILE: rtl/bpf_dp.sv
// Datapath: control points, Bernstein weights, accumulator, divider, output register.
module bpf_dp import bpf_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = MaxSegments,
  parameter int unsigned IW = 7,
  parameter int unsigned WW = 23,
  parameter int unsigned SW = 58,
  parameter int unsigned NW = 60
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bpf_cmd_t                 cmd_i,
  output bpf_status_t              status_o,
  input  logic [2:0]               action_i,
  input  logic [CoordW-1:0]        ax_i,
  input  logic [CoordW-1:0]        ay_i,
  input  logic [CoordW-1:0]        bx_i,
  input  logic [CoordW-1:0]        by_i,
  input  logic [CoordW-1:0]        cx_i,
  input  logic [CoordW-1:0]        cy_i,
  input  logic [SegW-1:0]          segments_i,
  output logic [CoordW-1:0]        out_x_o,
  output logic [CoordW-1:0]        out_y_o,
  output logic                     out_last_o
);

  logic [2:0]              act_q;
  logic signed [CoordW:0]  p_q [2][4];
  logic [CoordW-1:0]       pen_q [2];
  logic [IW-1:0]           n_q, i_q;
  logic [2*IW-1:0]         mm_q, ii_q, nn_q;
  logic [IW-1:0]           m_q;
  logic [WW-1:0]           w_q [4];
  logic [WW-1:0]           den_q;
  logic signed [SW-1:0]    acc_q [2];
  logic [NW-1:0]           dvd_q [2];
  logic [WW:0]             rem_q [2];
  logic                    neg_q [2];
  logic [CoordW-1:0]       ox_q, oy_q;
  logic                    olast_q;

  logic                    is_curve, is_quad, is_rel;
  logic [IW-1:0]           n_eff, m_d;
  logic [CoordW-1:0]       ain [2], bin [2], cin [2];
  logic [WW:0]             dsr;
  logic [3*IW-1:0]         t1, t2;

  always_comb begin
    case (action_e'(act_q))
      ACT_QUAD_ABS, ACT_QUAD_REL, ACT_CUBIC_ABS, ACT_CUBIC_REL: is_curve = 1'b1;
      default: is_curve = 1'b0;
    endcase
  end

  assign is_quad = (action_e'(action_i) == ACT_QUAD_ABS) ||
                   (action_e'(action_i) == ACT_QUAD_REL);
  assign is_rel  = (action_e'(action_i) == ACT_LINE_REL) ||
                   (action_e'(action_i) == ACT_QUAD_REL) ||
                   (action_e'(action_i) == ACT_CUBIC_REL);

  assign status_o.is_curve = is_curve;
  assign status_o.is_bad   = (act_q > 3'(ACT_CUBIC_REL));
  assign status_o.at_last  = (i_q == n_q);

  always_comb begin
    if (segments_i == '0) begin
      n_eff = IW'(1);
    end else if ((IW+SegW)'(segments_i) > (IW+SegW)'(MAX_SEGMENTS)) begin
      n_eff = IW'(MAX_SEGMENTS);
    end else begin
      n_eff = IW'(segments_i);
    end
  end

  assign ain[0] = ax_i; assign ain[1] = ay_i;
  assign bin[0] = bx_i; assign bin[1] = by_i;
  assign cin[0] = cx_i; assign cin[1] = cy_i;
  assign m_d    = n_q - i_q;
  assign dsr    = {den_q, 1'b0};
  assign t1     = (3*IW)'(mm_q) * (3*IW)'(i_q);
  assign t2     = (3*IW)'(ii_q) * (3*IW)'(m_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q[0] <= '0;
      pen_q[1] <= '0;
    end else if (cmd_i.emit) begin
      pen_q[0] <= is_curve ? (neg_q[0] ? ~dvd_q[0][CoordW-1:0] + 1'b1
                                       : dvd_q[0][CoordW-1:0]) : p_q[0][1][CoordW-1:0];
      pen_q[1] <= is_curve ? (neg_q[1] ? ~dvd_q[1][CoordW-1:0] + 1'b1
                                       : dvd_q[1][CoordW-1:0]) : p_q[1][1][CoordW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [CoordW:0]       base;
    logic signed [CoordW+WW+1:0]  mul;
    logic signed [SW-1:0]         prod;
    logic [SW+1:0]                nval;
    logic [WW+1:0]                trial;
    if (cmd_i.load) begin
      act_q <= action_i;
      n_q   <= n_eff;
      i_q   <= IW'(1);
      for (int l = 0; l < 2; l++) begin
        base = is_rel ? $signed({pen_q[l][CoordW-1], pen_q[l]}) : '0;
        p_q[l][0] <= $signed({pen_q[l][CoordW-1], pen_q[l]});
        p_q[l][1] <= $signed({ain[l][CoordW-1], ain[l]}) + base;
        p_q[l][2] <= $signed({bin[l][CoordW-1], bin[l]}) + base;
        p_q[l][3] <= is_quad ? $signed({bin[l][CoordW-1], bin[l]}) + base
                             : $signed({cin[l][CoordW-1], cin[l]}) + base;
      end
    end
    if (cmd_i.wgt1) begin
      m_q  <= m_d;
      mm_q <= (2*IW)'(m_d) * (2*IW)'(m_d);
      ii_q <= (2*IW)'(i_q) * (2*IW)'(i_q);
      nn_q <= (2*IW)'(n_q) * (2*IW)'(n_q);
    end
    if (cmd_i.wgt2) begin
      w_q[0] <= WW'((3*IW)'(mm_q) * (3*IW)'(m_q));
      w_q[1] <= WW'(t1) + WW'({t1, 1'b0});
      w_q[2] <= WW'(t2) + WW'({t2, 1'b0});
      w_q[3] <= WW'((3*IW)'(ii_q) * (3*IW)'(i_q));
      den_q  <= WW'((3*IW)'(nn_q) * (3*IW)'(n_q));
    end
    for (int l = 0; l < 2; l++) begin
      if (cmd_i.mac) begin
        mul  = p_q[l][cmd_i.term] * $signed({1'b0, w_q[cmd_i.term]});
        prod = SW'(mul);
        acc_q[l] <= ((cmd_i.term == 2'd0) ? '0 : acc_q[l]) + prod;
      end
      if (cmd_i.prep) begin
        // N = 2*sum + den; floor(N / 2den) is the rounded quotient
        nval = {acc_q[l][SW-1], acc_q[l], 1'b0} + (SW+2)'(den_q);
        neg_q[l] <= nval[SW+1];
        dvd_q[l] <= NW'(nval[SW+1] ? ~nval + (SW+2)'(dsr) : nval);
        rem_q[l] <= '0;
      end
      if (cmd_i.div_step) begin
        trial = {rem_q[l], dvd_q[l][NW-1]};
        if (trial >= {1'b0, dsr}) begin
          rem_q[l] <= (WW+1)'(trial - {1'b0, dsr});
          dvd_q[l] <= {dvd_q[l][NW-2:0], 1'b1};
        end else begin
          rem_q[l] <= trial[WW:0];
          dvd_q[l] <= {dvd_q[l][NW-2:0], 1'b0};
        end
      end
    end
    if (cmd_i.emit) begin
      ox_q    <= is_curve ? (neg_q[0] ? ~dvd_q[0][CoordW-1:0] + 1'b1
                                      : dvd_q[0][CoordW-1:0]) : p_q[0][1][CoordW-1:0];
      oy_q    <= is_curve ? (neg_q[1] ? ~dvd_q[1][CoordW-1:0] + 1'b1
                                      : dvd_q[1][CoordW-1:0]) : p_q[1][1][CoordW-1:0];
      olast_q <= !is_curve || (i_q == n_q);
      i_q     <= i_q + 1'b1;
    end
  end

  assign out_x_o    = ox_q;
  assign out_y_o    = oy_q;
  assign out_last_o = olast_q;

endmodule

FILE: rtl/bpf_ctrl.sv
// Sequencer: steps curves through weights, accumulate, divide and emit.
module bpf_ctrl import bpf_pkg::*; #(
  parameter int unsigned DIV_STEPS = 60
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output bpf_cmd_t    cmd_o,
  input  bpf_status_t status_i
);
  `include "bezier_path_flattener_unit_macros.svh"

  localparam int unsigned CntW = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_WGT1, ST_WGT2, ST_MAC, ST_PREP, ST_DIV, ST_EMIT
  } state_e;

  state_e          state_q, state_d;
  logic [1:0]      term_q, term_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovalid_q, ovalid_d;
  logic            out_free;

  assign out_free      = !ovalid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovalid_q;

  always_comb begin
    state_d = state_q;
    term_d  = term_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.term = term_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status_i.is_bad) begin
          state_d = ST_IDLE;
        end else if (status_i.is_curve) begin
          state_d = ST_WGT1;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_WGT1: begin
        cmd_o.wgt1 = 1'b1;
        state_d    = ST_WGT2;
      end
      ST_WGT2: begin
        cmd_o.wgt2 = 1'b1;
        term_d     = '0;
        state_d    = ST_MAC;
      end
      ST_MAC: begin
        cmd_o.mac = 1'b1;
        term_d    = term_q + 1'b1;
        if (term_q == 2'd3) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = '0;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(DIV_STEPS - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = (!status_i.is_curve || status_i.at_last) ? ST_IDLE : ST_WGT1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign ovalid_d = cmd_o.emit ? 1'b1 : (m_axis_tready ? 1'b0 : ovalid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      term_q   <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      term_q   <= term_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  `BPF_ASSERT_NEXT(a_load_decodes, cmd_o.load, state_q == ST_DECODE, "load not followed by decode")
  `BPF_ASSERT_NOW(a_emit_free, cmd_o.emit, out_free, "emit into an occupied output register")
  `BPF_ASSERT_NOW(a_div_bound, state_q == ST_DIV, cnt_q <= CntW'(DIV_STEPS - 1), "divider overrun")
  `BPF_ASSERT_NOW(a_valid_src, $rose(ovalid_q), $past(cmd_o.emit), "output valid without emit")

endmodule

FILE: rtl/bezier_path_flattener_unit.sv
// Top level of the path flattener: stream ports, sequencer and datapath.
// Restart and relative line: one point, passed through the decode and emit states to the output register.
// Curve: each point passes through the weight, accumulate, prepare, divide and emit states; the bit-serial
// divider forms the rounded quotient.
// A new item is taken only when the previous one has handed its last point to the output register.
// Reset (rst_ni low, asynchronous) clears the pen to the origin and empties the output.
module bezier_path_flattener_unit import bpf_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = MaxSegments
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pt_a_x[31:0], pt_a_y[63:32], pt_b_x[95:64], pt_b_y[127:96],
  // pt_c_x[159:128], pt_c_y[191:160], segments[198:192], zero [199]
  input  logic [199:0] s_axis_tdata,
  // action[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x[31:0], out_y[63:32]
  output logic [63:0]  m_axis_tdata,
  // last_point
  output logic         m_axis_tlast
);

  // index width, weight width, sum width and divider length follow the segment limit
  localparam int unsigned IW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned WW = 3 * IW + 2;
  localparam int unsigned SW = WW + 35;
  localparam int unsigned NW = SW + 2;

  bpf_cmd_t    cmd;
  bpf_status_t status;
  logic [CoordW-1:0] out_x, out_y;

  // sequencer: one state per step of the per-point evaluation
  bpf_ctrl #(
    .DIV_STEPS (NW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd),
    .status_i      (status)
  );

  // datapath: both coordinates run side by side in two lanes
  bpf_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .IW           (IW),
    .WW           (WW),
    .SW           (SW),
    .NW           (NW)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .action_i   (s_axis_tuser),
    .ax_i       (s_axis_tdata[31:0]),
    .ay_i       (s_axis_tdata[63:32]),
    .bx_i       (s_axis_tdata[95:64]),
    .by_i       (s_axis_tdata[127:96]),
    .cx_i       (s_axis_tdata[159:128]),
    .cy_i       (s_axis_tdata[191:160]),
    .segments_i (s_axis_tdata[198:192]),
    .out_x_o    (out_x),
    .out_y_o    (out_y),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {out_y, out_x};

endmodule

FILE: test/tb.sv
// Self-checking stream testbench for the path flattener unit.
module tb;
  import bpf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0]         act;
    logic signed [31:0] ax, ay, bx, by, cx, cy;
    logic [6:0]         seg;
  } cmd_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic        last;
  } point_t;

  // Directed row: command plus an optional typed expectation (single point).
  typedef struct {
    cmd_t        c;
    logic        typed;
    logic [31:0] ex;
    logic [31:0] ey;
  } row_t;

  localparam int unsigned NumRandom = 500;
  localparam int unsigned QuietTail = 60;
  localparam int unsigned DrainCycles = 400;
  localparam logic signed [31:0] Pmax = 32'sh7fffffff;
  localparam logic signed [31:0] Pmin = 32'sh80000000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [199:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tlast;

  logic signed [31:0] pen_x = '0;
  logic signed [31:0] pen_y = '0;
  point_t             points_due[$];
  int                 fails = 0;
  bit                 quiet = 1'b0;

  bezier_path_flattener_unit uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Append one expected point behind those already booked.
  task automatic book_point(input point_t p);
    points_due.insert(points_due.size(), p);
  endtask

  // Exact Bernstein sum, rounded to nearest with ties upward, wrapped to 32 bits.
  function automatic logic [31:0] bezier_coord(longint p0, longint p1, longint p2,
                                               longint p3, longint i, longint n);
    longint m, den, acc, q, r;
    m   = n - i;
    den = n * n * n;
    acc = p0 * (m * m * m) + p1 * (3 * m * m * i) + p2 * (3 * m * i * i)
        + p3 * (i * i * i);
    q = acc / den;
    r = acc % den;
    if (r < 0) begin
      q = q - 1;
      r = r + den;
    end
    if (2 * r >= den) q = q + 1;
    return q[31:0];
  endfunction

  // Advance the pen for one accepted command and queue the points it causes.
  task automatic flatten(input cmd_t c);
    longint px, py, k1x, k1y, k2x, k2y, k3x, k3y, n;
    point_t p;
    px = longint'(pen_x);
    py = longint'(pen_y);
    if (c.act == ACT_RESTART || c.act == ACT_LINE_REL) begin
      if (c.act == ACT_RESTART) begin
        pen_x = c.ax;
        pen_y = c.ay;
      end else begin
        pen_x = pen_x + c.ax;
        pen_y = pen_y + c.ay;
      end
      p.x = pen_x; p.y = pen_y; p.last = 1'b1;
      book_point(p);
    end else if (c.act <= ACT_CUBIC_REL) begin
      n = longint'(c.seg);
      if (n < 1) n = 1;
      if (n > MaxSegments) n = MaxSegments;
      k1x = c.ax; k1y = c.ay; k2x = c.bx; k2y = c.by;
      if (c.act == ACT_QUAD_ABS || c.act == ACT_QUAD_REL) begin
        k3x = c.bx; k3y = c.by;
      end else begin
        k3x = c.cx; k3y = c.cy;
      end
      if (c.act == ACT_QUAD_REL || c.act == ACT_CUBIC_REL) begin
        k1x += px; k1y += py; k2x += px; k2y += py; k3x += px; k3y += py;
      end
      for (longint i = 1; i <= n; i++) begin
        p.x    = bezier_coord(px, k1x, k2x, k3x, i, n);
        p.y    = bezier_coord(py, k1y, k2y, k3y, i, n);
        p.last = (i == n);
        book_point(p);
        pen_x = p.x;
        pen_y = p.y;
      end
    end
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return Pmax;
      1: return Pmin;
      2, 3, 4: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   w;
    w = $urandom_range(0, 99);
    if (w < 10) c.act = ACT_RESTART;
    else if (w < 20) c.act = ACT_LINE_REL;
    else if (w < 97) c.act = 3'($urandom_range(ACT_QUAD_ABS, ACT_CUBIC_REL));
    else c.act = 3'($urandom_range(6, 7));
    c.ax = rand_coord(); c.ay = rand_coord();
    c.bx = rand_coord(); c.by = rand_coord();
    c.cx = rand_coord(); c.cy = rand_coord();
    // Keep most curves short; a few reach the limit or beyond it.
    w = $urandom_range(0, 99);
    if (w < 80) c.seg = 7'($urandom_range(1, 8));
    else if (w < 92) c.seg = 7'($urandom_range(9, 64));
    else if (w < 96) c.seg = 7'($urandom_range(65, 127));
    else c.seg = 7'd0;
    return c;
  endfunction

  // Present one command, hold it until the transfer, then book its points.
  task automatic send(input cmd_t c, input logic typed, input logic [31:0] ex,
                      input logic [31:0] ey);
    point_t p;
    int     gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.act;
    s_axis_tdata  <= {1'b0, c.seg, c.cy, c.cx, c.by, c.bx, c.ay, c.ax};
    do @(posedge clk_i); while (!s_axis_tready);
    flatten(c);
    if (typed) begin
      // the typed value stands in for the single booked point
      p.x = ex; p.y = ey; p.last = 1'b1;
      points_due[points_due.size() - 1] = p;
    end
  endtask

  // Output side: random bursts of back-pressure, none in the quiet tail.
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 18);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni;
    end
  end

  // Compare every output transfer with the oldest booked point.
  always @(posedge clk_i) begin
    point_t p;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (points_due.size() == 0) begin
        $display("%0t: unexpected point x=%h y=%h last=%b", $time,
                 m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tlast);
        fails++;
      end else begin
        p = points_due.pop_front();
        if (m_axis_tdata[31:0] !== p.x) begin
          $display("%0t: x expected %h actual %h", $time, p.x, m_axis_tdata[31:0]);
          fails++;
        end
        if (m_axis_tdata[63:32] !== p.y) begin
          $display("%0t: y expected %h actual %h", $time, p.y, m_axis_tdata[63:32]);
          fails++;
        end
        if (m_axis_tlast !== p.last) begin
          $display("%0t: last expected %b actual %b", $time, p.last, m_axis_tlast);
          fails++;
        end
      end
    end
  end

  row_t directed[$];

  function automatic row_t mk(logic [2:0] act, logic signed [31:0] ax, ay, bx, by,
                              cx, cy, logic [6:0] seg, logic typed = 1'b0,
                              logic [31:0] ex = '0, logic [31:0] ey = '0);
    row_t r;
    r.c.act = act; r.c.ax = ax; r.c.ay = ay; r.c.bx = bx; r.c.by = by;
    r.c.cx = cx; r.c.cy = cy; r.c.seg = seg;
    r.typed = typed; r.ex = ex; r.ey = ey;
    return r;
  endfunction

  // Append one row to the directed table.
  task automatic add_row(input row_t r);
    directed.insert(directed.size(), r);
  endtask

  initial begin
    int     done;
    cmd_t   c;
    // Reset leaves the pen at the origin: a zero line stays there.
    add_row(mk(ACT_LINE_REL, 0, 0, 0, 0, 0, 0, 7'd1, 1'b1, 32'h0, 32'h0));
    add_row(mk(ACT_RESTART, Pmax, Pmin, 0, 0, 0, 0, 7'd1, 1'b1,
               32'h7fffffff, 32'h80000000));
    // Line past the largest value wraps round.
    add_row(mk(ACT_LINE_REL, 1, -1, 0, 0, 0, 0, 7'd0, 1'b1,
               32'h80000000, 32'h7fffffff));
    add_row(mk(ACT_RESTART, Pmin, Pmax, Pmax, Pmin, Pmax, Pmin, 7'd127, 1'b1,
               32'h80000000, 32'h7fffffff));
    add_row(mk(ACT_RESTART, 0, 0, 0, 0, 0, 0, 7'd1, 1'b1, 32'h0, 32'h0));
    // Unknown actions: nothing comes out, pen holds.
    add_row(mk(3'd6, Pmax, Pmax, Pmax, Pmax, Pmax, Pmax, 7'd127));
    add_row(mk(3'd7, Pmin, Pmin, Pmin, Pmin, Pmin, Pmin, 7'd5));
    add_row(mk(ACT_QUAD_ABS, 32'sh10000, 32'sh20000, 32'sh30000, -32'sh10000,
               0, 0, 7'd1));
    add_row(mk(ACT_QUAD_ABS, 32'sh10000, 32'sh20000, 32'sh30000, -32'sh10000,
               0, 0, 7'd4));
    add_row(mk(ACT_QUAD_REL, 32'sh8000, -32'sh8000, 32'sh18000, 32'sh4000,
               0, 0, 7'd3));
    add_row(mk(ACT_CUBIC_ABS, Pmax, Pmin, Pmin, Pmax, Pmax, Pmax, 7'd64));
    // Segment count zero acts as one; above the limit it saturates.
    add_row(mk(ACT_CUBIC_REL, Pmax, Pmax, Pmin, Pmin, Pmax, Pmin, 7'd0));
    add_row(mk(ACT_CUBIC_REL, Pmin, Pmax, Pmax, Pmin, Pmin, Pmax, 7'd127));
    add_row(mk(ACT_QUAD_REL, Pmax, Pmax, Pmax, Pmax, 0, 0, 7'd65));
    add_row(mk(ACT_CUBIC_ABS, -1, -1, -1, -1, -1, -1, 7'd7));
    add_row(mk(ACT_QUAD_ABS, 1, 1, 1, 1, 0, 0, 7'd2));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[k]) send(directed[k].c, directed[k].typed, directed[k].ex,
                               directed[k].ey);
    done = 0;
    while (done < NumRandom) begin
      c = rand_cmd();
      if (done >= NumRandom - QuietTail) quiet = 1'b1;
      send(c, 1'b0, '0, '0);
      if (c.act <= ACT_CUBIC_REL) done++;
    end
    s_axis_tvalid <= 1'b0;

    while (points_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: bezier_path_flattener_unit.f
+incdir+rtl
rtl/bpf_pkg.sv
rtl/bpf_dp.sv
rtl/bpf_ctrl.sv
rtl/bezier_path_flattener_unit.sv
test/tb.sv
